[rtl/core/line_rasterizer_core_macros.svh]
// Assertion macros for the line rasterizer RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef LINE_RASTERIZER_CORE_MACROS_SVH
`define LINE_RASTERIZER_CORE_MACROS_SVH

// Clocked check, off while reset is asserted.
`define LR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Next-cycle check: cons must hold in the cycle after ante, off during reset.
`define LR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lr_pkg.sv]
// Shared types, constants and helpers for the line rasterizer.
// No dependencies.
package lr_pkg;

  localparam int CoordW    = 10;
  localparam int RowStride = 800;
  localparam int ColorW    = 32;
  localparam int AddrW     = 32;
  localparam int RemW      = CoordW + 1;
  localparam int ErrW      = CoordW + 2;
  localparam int RowOffW   =
    $clog2(((1 << CoordW) - 1) * RowStride + (1 << CoordW));

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdStep = 1'b1;

  typedef logic [CoordW-1:0] coord_t;

  typedef struct packed {
    logic load;
    logic step;
  } lr_ctl_t;

  typedef struct packed {
    logic [ColorW-1:0] color;
    coord_t            y_end;
    coord_t            x_end;
    coord_t            y_start;
    coord_t            x_start;
  } lr_line_t;

  typedef struct packed {
    logic                last;
    logic [ColorW-1:0]   color;
    logic [RowOffW-1:0]  row_off;
    coord_t              y;
    coord_t              x;
  } lr_pix_t;

  function automatic coord_t step_coord(coord_t c, logic down);
    return down ? c - coord_t'(1) : c + coord_t'(1);
  endfunction

endpackage

[rtl/core/lr_stepper.sv]
// Bresenham line state: load of a new line and one pixel step per word.
// Depends on lr_pkg and line_rasterizer_core_macros.svh.
`include "line_rasterizer_core_macros.svh"

module lr_stepper (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lr_pkg::lr_ctl_t  ctl_i,
  input  lr_pkg::lr_line_t line_i,
  output lr_pkg::lr_pix_t  pix_o,
  output logic             busy_o
);
  import lr_pkg::*;

  coord_t              cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  coord_t              major_q, major_d, minor_q, minor_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic signed [ErrW-1:0] err_q, err_d, err_t;
  logic [RowOffW-1:0]  row_off_q, row_off_d;
  logic                x_dec_q, x_dec_d, y_dec_q, y_dec_d;
  logic                x_major_q, x_major_d, busy_q, busy_d;
  logic [ColorW-1:0]   color_q, color_d;

  coord_t dx, dy, ld_major, ld_minor;
  logic   ld_x_dec, ld_y_dec, ld_x_major;
  logic   minor_step, y_step;

  always_comb begin
    ld_x_dec   = line_i.x_end < line_i.x_start;
    ld_y_dec   = line_i.y_end < line_i.y_start;
    dx         = ld_x_dec ? line_i.x_start - line_i.x_end : line_i.x_end - line_i.x_start;
    dy         = ld_y_dec ? line_i.y_start - line_i.y_end : line_i.y_end - line_i.y_start;
    ld_x_major = dx >= dy;
    ld_major   = ld_x_major ? dx : dy;
    ld_minor   = ld_x_major ? dy : dx;
  end

  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    major_d   = major_q;
    minor_d   = minor_q;
    rem_d     = rem_q;
    err_d     = err_q;
    row_off_d = row_off_q;
    x_dec_d   = x_dec_q;
    y_dec_d   = y_dec_q;
    x_major_d = x_major_q;
    busy_d    = busy_q;
    color_d   = color_q;
    err_t     = err_q;
    minor_step = err_q > 0;
    y_step     = x_major_q ? minor_step : 1'b1;
    if (ctl_i.load) begin
      x_dec_d   = ld_x_dec;
      y_dec_d   = ld_y_dec;
      x_major_d = ld_x_major;
      major_d   = ld_major;
      minor_d   = ld_minor;
      err_d     = $signed(ErrW'(ld_minor)) - $signed(ErrW'(ld_major >> 1));
      cur_x_d   = line_i.x_start;
      cur_y_d   = line_i.y_start;
      row_off_d = RowOffW'(line_i.y_start * RowStride);
      rem_d     = RemW'(ld_major) + RemW'(1);
      color_d   = line_i.color;
      busy_d    = 1'b1;
    end else if (ctl_i.step && busy_q) begin
      if (minor_step) begin
        err_t = err_q - $signed(ErrW'(major_q));
      end
      if (x_major_q) begin
        cur_x_d = step_coord(cur_x_q, x_dec_q);
        if (minor_step) begin
          cur_y_d = step_coord(cur_y_q, y_dec_q);
        end
      end else begin
        cur_y_d = step_coord(cur_y_q, y_dec_q);
        if (minor_step) begin
          cur_x_d = step_coord(cur_x_q, x_dec_q);
        end
      end
      if (y_step) begin
        row_off_d = y_dec_q ? row_off_q - RowOffW'(RowStride)
                            : row_off_q + RowOffW'(RowStride);
      end
      err_d  = err_t + $signed(ErrW'(minor_q));
      rem_d  = rem_q - RemW'(1);
      busy_d = rem_q != RemW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      major_q   <= '0;
      minor_q   <= '0;
      rem_q     <= '0;
      err_q     <= '0;
      row_off_q <= '0;
      x_dec_q   <= 1'b0;
      y_dec_q   <= 1'b0;
      x_major_q <= 1'b0;
      busy_q    <= 1'b0;
      color_q   <= '0;
    end else begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      major_q   <= major_d;
      minor_q   <= minor_d;
      rem_q     <= rem_d;
      err_q     <= err_d;
      row_off_q <= row_off_d;
      x_dec_q   <= x_dec_d;
      y_dec_q   <= y_dec_d;
      x_major_q <= x_major_d;
      busy_q    <= busy_d;
      color_q   <= color_d;
    end
  end

  assign pix_o.x       = cur_x_q;
  assign pix_o.y       = cur_y_q;
  assign pix_o.row_off = row_off_q;
  assign pix_o.color   = color_q;
  assign pix_o.last    = rem_q == RemW'(1);
  assign busy_o        = busy_q;

  `LR_ASSERT(a_busy_rem, busy_q == (rem_q != '0), "busy out of step with pixel count")
  `LR_ASSERT(a_row_off, busy_q |-> (row_off_q == RowOffW'(cur_y_q * RowStride)),
             "row offset does not track current row")
  `LR_ASSERT(a_load_busy, ctl_i.load |=> busy_q, "load did not start a line")

endmodule

[rtl/core/line_rasterizer_core.sv]
// Line rasterizer top level: stream ports, base register, output register.
// Depends on lr_pkg, lr_stepper and line_rasterizer_core_macros.svh.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: line, tuser: command
//  m_axis    out  tvalid/tready          tdata: pixel, tlast: last pixel
//  cfg       in   cfg_we_i               cfg_wdata_i: frame base
//
// One word per cycle on both sides unless m_axis stalls; a step's pixel is registered.
// The line state advances in the cycle the word is taken; the output register
// decouples the sides, so a new word is taken while the last pixel drains.
// Reset clears the line state (idle) and the frame base; no clearing pass.
// A stalled output holds s_axis_tready_o low only while its register is full.
`include "line_rasterizer_core_macros.svh"

module line_rasterizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // x_start[9:0] y_start[19:10] x_end[29:20] y_end[39:30] line_color[71:40]
  input  logic [71:0] s_axis_tdata_i,
  // command[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pixel_x[9:0] pixel_y[19:10] pixel_address[51:20] pixel_value[83:52] zero[87:84]
  output logic [87:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);
  import lr_pkg::*;

  logic [AddrW-1:0]  base_q;
  logic              m_valid_q, m_valid_d;
  coord_t            px_q, py_q;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [ColorW-1:0] val_q;
  logic              last_q;

  lr_ctl_t  ctl;
  lr_line_t line;
  lr_pix_t  pix;
  logic     busy;
  logic     in_fire, step_fire;
  logic [RowOffW-1:0] lin_off;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign ctl.load        = in_fire && (s_axis_tuser_i == CmdLoad);
  assign ctl.step        = in_fire && (s_axis_tuser_i == CmdStep);
  assign step_fire       = ctl.step && busy;
  assign line            = lr_line_t'(s_axis_tdata_i);

  lr_stepper u_stepper (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .line_i (line),
    .pix_o  (pix),
    .busy_o (busy)
  );

  always_comb begin
    lin_off   = pix.row_off + RowOffW'(pix.x);
    addr_d    = base_q + AddrW'({lin_off, 2'b00});
    m_valid_d = m_valid_q;
    if (step_fire) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      px_q   <= pix.x;
      py_q   <= pix.y;
      addr_q <= addr_d;
      val_q  <= pix.color;
      last_q <= pix.last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'b0000, val_q, addr_q, py_q, px_q};
  assign m_axis_tlast_o  = last_q;

  `LR_ASSERT(a_ready_empty, !m_valid_q |-> s_axis_tready_o, "empty output stalls input")
  `LR_ASSERT_NEXT(a_step_emits, step_fire, m_axis_tvalid_o, "active step gave no pixel")
  `LR_ASSERT_NEXT(a_hold, m_valid_q && !m_axis_tready_i, m_valid_q, "pixel word dropped")

endmodule
